[rtl/core/glos_pkg.sv]
// Shared constants, command/status structs for the grid line-of-sight checker.
// Used by every module under rtl/core.
package glos_pkg;

    localparam int COORD_W    = 16;
    localparam int QUO_W      = COORD_W - 1;
    localparam int DIM_W      = 7;
    localparam int CS_W       = 8;
    localparam int IDX_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int ERR_W      = COORD_W + 2;
    localparam int DIV_CNT_W  = $clog2(QUO_W + 1);

    localparam int DEF_MAX_COLUMNS = 64;
    localparam int DEF_MAX_ROWS    = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE   = 2'd2;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [1:0] PRB_CUR = 2'd0;
    localparam logic [1:0] PRB_NX  = 2'd1;
    localparam logic [1:0] PRB_NY  = 2'd2;

    localparam logic [1:0] OPD_START_X = 2'd0;
    localparam logic [1:0] OPD_START_Y = 2'd1;
    localparam logic [1:0] OPD_END_X   = 2'd2;
    localparam logic [1:0] OPD_END_Y   = 2'd3;

    typedef struct packed {
        logic       clr_en;
        logic       map_wr;
        logic       q_load;
        logic       div_start;
        logic [1:0] div_sel;
        logic       quo_store;
        logic       setup;
        logic       probe;
        logic [1:0] probe_sel;
        logic       step;
        logic       out_load;
        logic       out_value;
    } glos_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic query_bad;
        logic div_done;
        logic probe_open;
        logic at_target;
        logic diag;
    } glos_sts_t;

endpackage

[rtl/core/glos_div.sv]
// Restoring divider: one quotient bit per cycle, positions by cell size.
// Depends on glos_pkg.
module glos_div
    import glos_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [QUO_W-1:0] dividend,
    input  logic [CS_W-1:0]  divisor,
    output logic             done,
    output logic [QUO_W-1:0] quotient
);

    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [QUO_W-1:0]     q_reg, q_next;
    logic [CS_W-1:0]      rem_reg, rem_next;
    logic [CS_W:0]        shifted;

    always_comb
    begin
        shifted  = {rem_reg, q_reg[QUO_W-1]};
        cnt_next = cnt_reg;
        q_next   = q_reg;
        rem_next = rem_reg;
        if (start)
        begin
            cnt_next = DIV_CNT_W'(QUO_W);
            q_next   = dividend;
            rem_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (shifted >= {1'b0, divisor})
            begin
                rem_next = CS_W'(shifted - {1'b0, divisor});
                q_next   = {q_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[CS_W-1:0];
                q_next   = {q_reg[QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

    assign done     = (cnt_reg == '0);
    assign quotient = q_reg;

endmodule

[rtl/core/glos_dp.sv]
// Datapath: config registers, occupancy map memory, divider, line-walk registers.
// Depends on glos_pkg and glos_div.
module glos_dp
    import glos_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [IDX_W-1:0]      cell_index,
    input  logic                  cell_free,
    input  logic [COORD_W-1:0]    start_x,
    input  logic [COORD_W-1:0]    start_y,
    input  logic [COORD_W-1:0]    end_x,
    input  logic [COORD_W-1:0]    end_y,
    input  glos_cmd_t             cmd,
    output glos_sts_t             sts,
    output logic                  line_clear
);

    localparam int MAP_DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int LIN_W     = 2 * DIM_W + 1;

    logic [DIM_W-1:0] grid_width_reg, grid_height_reg;
    logic [CS_W-1:0]  cell_size_reg;
    logic [DIM_W-1:0] eff_w, eff_h;
    logic [CS_W-1:0]  cs_eff;

    logic             map_mem [MAP_DEPTH];
    logic [MAP_AW-1:0] clr_cnt_reg;
    logic             rd_reg, inb_reg;

    logic [COORD_W-1:0] coord_reg [4];
    logic [QUO_W-1:0]   x_reg, y_reg, tx_reg, ty_reg;
    logic signed [ERR_W-1:0] dx_reg, dy_reg, err_reg;
    logic               stx_pos_reg, sty_pos_reg;
    logic               line_clear_reg;

    logic               div_done;
    logic [QUO_W-1:0]   quotient;

    logic signed [COORD_W-1:0] ddx, ddy, adx, ady;
    logic signed [ERR_W:0]     e2, dx_ext, dy_ext;
    logic                      mx, my;
    logic [COORD_W-1:0]        px, py;
    logic                      inb;
    logic [LIN_W-1:0]          lin;
    logic [MAP_AW-1:0]         probe_addr;
    logic                      wr_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= '0;
            grid_height_reg <= '0;
            cell_size_reg   <= CS_W'(1);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_GRID_WIDTH:  grid_width_reg  <= cfg_data[DIM_W-1:0];
                CFG_GRID_HEIGHT: grid_height_reg <= cfg_data[DIM_W-1:0];
                CFG_CELL_SIZE:   cell_size_reg   <= cfg_data[CS_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        eff_w  = (32'(grid_width_reg) > 32'(MAX_COLUMNS)) ? DIM_W'(MAX_COLUMNS)
                                                           : grid_width_reg;
        eff_h  = (32'(grid_height_reg) > 32'(MAX_ROWS)) ? DIM_W'(MAX_ROWS)
                                                         : grid_height_reg;
        cs_eff = (cell_size_reg == '0) ? CS_W'(1) : cell_size_reg;
    end

    // map memory: clearing sweep, cell writes, one read port
    assign wr_ok = (32'(cell_index) < 32'(MAP_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_en)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_en)
        begin
            map_mem[clr_cnt_reg] <= 1'b0;
        end
        else if (cmd.map_wr && wr_ok)
        begin
            map_mem[MAP_AW'(cell_index)] <= cell_free;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.probe)
        begin
            rd_reg  <= map_mem[probe_addr];
            inb_reg <= inb;
        end
    end

    // query operands and quotients
    always_ff @(posedge clk)
    begin
        if (cmd.q_load)
        begin
            coord_reg[OPD_START_X] <= start_x;
            coord_reg[OPD_START_Y] <= start_y;
            coord_reg[OPD_END_X]   <= end_x;
            coord_reg[OPD_END_Y]   <= end_y;
        end
    end

    glos_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (coord_reg[cmd.div_sel][QUO_W-1:0]),
        .divisor  (cs_eff),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        ddx    = signed'({1'b0, tx_reg}) - signed'({1'b0, x_reg});
        ddy    = signed'({1'b0, ty_reg}) - signed'({1'b0, y_reg});
        adx    = ddx[COORD_W-1] ? -ddx : ddx;
        ady    = ddy[COORD_W-1] ? -ddy : ddy;
        e2     = {err_reg, 1'b0};
        dx_ext = (ERR_W+1)'(dx_reg);
        dy_ext = (ERR_W+1)'(dy_reg);
        mx     = (e2 >= dy_ext);
        my     = (e2 <= dx_ext);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.quo_store)
        begin
            case (cmd.div_sel)
                OPD_START_X: x_reg  <= quotient;
                OPD_START_Y: y_reg  <= quotient;
                OPD_END_X:   tx_reg <= quotient;
                OPD_END_Y:   ty_reg <= quotient;
                default:     ;
            endcase
        end
        else if (cmd.setup)
        begin
            dx_reg      <= ERR_W'(adx);
            dy_reg      <= -ERR_W'(ady);
            err_reg     <= ERR_W'(adx) - ERR_W'(ady);
            stx_pos_reg <= (x_reg < tx_reg);
            sty_pos_reg <= (y_reg < ty_reg);
        end
        else if (cmd.step)
        begin
            err_reg <= err_reg + (mx ? dy_reg : '0) + (my ? dx_reg : '0);
            if (mx)
            begin
                x_reg <= stx_pos_reg ? x_reg + 1'b1 : x_reg - 1'b1;
            end
            if (my)
            begin
                y_reg <= sty_pos_reg ? y_reg + 1'b1 : y_reg - 1'b1;
            end
        end
    end

    // probe point, bounds and linear address
    always_comb
    begin
        px = {1'b0, x_reg};
        py = {1'b0, y_reg};
        case (cmd.probe_sel)
            PRB_NX:  px = stx_pos_reg ? {1'b0, x_reg} + 1'b1 : {1'b0, x_reg} - 1'b1;
            PRB_NY:  py = sty_pos_reg ? {1'b0, y_reg} + 1'b1 : {1'b0, y_reg} - 1'b1;
            default: ;
        endcase
        inb        = (px < COORD_W'(eff_w)) && (py < COORD_W'(eff_h));
        lin        = LIN_W'(py[DIM_W-1:0]) * LIN_W'(eff_w) + LIN_W'(px[DIM_W-1:0]);
        probe_addr = MAP_AW'(lin);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            line_clear_reg <= cmd.out_value;
        end
    end

    assign line_clear = line_clear_reg;

    always_comb
    begin
        sts.clr_last   = (32'(clr_cnt_reg) == MAP_DEPTH - 1);
        sts.query_bad  = (eff_w == '0) || (eff_h == '0)
                         || coord_reg[OPD_START_X][COORD_W-1]
                         || coord_reg[OPD_START_Y][COORD_W-1]
                         || coord_reg[OPD_END_X][COORD_W-1]
                         || coord_reg[OPD_END_Y][COORD_W-1];
        sts.div_done   = div_done;
        sts.probe_open = inb_reg & rd_reg;
        sts.at_target  = (x_reg == tx_reg) && (y_reg == ty_reg);
        sts.diag       = mx & my;
    end

endmodule

[rtl/core/glos_ctrl.sv]
// Controller: clearing sweep, request intake, divide sequence, line walk, result beat.
// Depends on glos_pkg.
module glos_ctrl
    import glos_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic      req_type,
    output logic      out_valid,
    input  logic      out_ready,
    output glos_cmd_t cmd,
    input  glos_sts_t sts
);

    localparam logic [3:0] S_CLEAR     = 4'd0;
    localparam logic [3:0] S_IDLE      = 4'd1;
    localparam logic [3:0] S_CHECK     = 4'd2;
    localparam logic [3:0] S_DIV_START = 4'd3;
    localparam logic [3:0] S_DIV_RUN   = 4'd4;
    localparam logic [3:0] S_SETUP     = 4'd5;
    localparam logic [3:0] S_PROBE     = 4'd6;
    localparam logic [3:0] S_EVAL      = 4'd7;
    localparam logic [3:0] S_RESULT    = 4'd8;

    logic [3:0] state_reg, state_next;
    logic [1:0] sel_reg, sel_next;
    logic [1:0] phase_reg, phase_next;
    logic       res_reg, res_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        phase_next     = phase_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.div_sel    = sel_reg;
        cmd.probe_sel  = phase_reg;
        cmd.out_value  = res_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (req_type == REQ_WRITE)
                    begin
                        cmd.map_wr = 1'b1;
                    end
                    else
                    begin
                        cmd.q_load = 1'b1;
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                sel_next = OPD_START_X;
                if (sts.query_bad)
                begin
                    res_next   = 1'b0;
                    state_next = S_RESULT;
                end
                else
                begin
                    state_next = S_DIV_START;
                end
            end
            S_DIV_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_RUN;
            end
            S_DIV_RUN:
            begin
                if (sts.div_done)
                begin
                    cmd.quo_store = 1'b1;
                    if (sel_reg == OPD_END_Y)
                    begin
                        state_next = S_SETUP;
                    end
                    else
                    begin
                        sel_next   = sel_reg + 1'b1;
                        state_next = S_DIV_START;
                    end
                end
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                phase_next = PRB_CUR;
                state_next = S_PROBE;
            end
            S_PROBE:
            begin
                cmd.probe  = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = S_PROBE;
                if (!sts.probe_open)
                begin
                    res_next   = 1'b0;
                    state_next = S_RESULT;
                end
                else
                begin
                    case (phase_reg)
                        PRB_CUR:
                        begin
                            if (sts.at_target)
                            begin
                                res_next   = 1'b1;
                                state_next = S_RESULT;
                            end
                            else if (sts.diag)
                            begin
                                phase_next = PRB_NX;
                            end
                            else
                            begin
                                cmd.step = 1'b1;
                            end
                        end
                        PRB_NX:
                        begin
                            phase_next = PRB_NY;
                        end
                        default:
                        begin
                            cmd.step   = 1'b1;
                            phase_next = PRB_CUR;
                        end
                    endcase
                end
            end
            S_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            sel_reg       <= OPD_START_X;
            phase_reg     <= PRB_CUR;
            res_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            phase_reg     <= phase_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

[rtl/core/grid_line_of_sight_check.sv]
// Grid line-of-sight checker: top level joining glos_ctrl and glos_dp (glos_pkg, glos_div).
// Map write beat: taken in IDLE, back to back. Query beat: a check state, four divides on the
// shared 1-bit/cycle divider, setup, then a probe and evaluate per cell walked plus two more
// per diagonal step, then the result load; an empty grid or negative coordinate skips to it.
// One query in flight: the next beat is taken once its result is loaded (stalls on out_ready).
// Reset: clearing sweep of the whole map; no beat accepted.
module grid_line_of_sight_check
    import glos_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  req_type,
    input  logic [IDX_W-1:0]      cell_index,
    input  logic                  cell_free,
    input  logic [COORD_W-1:0]    start_x,
    input  logic [COORD_W-1:0]    start_y,
    input  logic [COORD_W-1:0]    end_x,
    input  logic [COORD_W-1:0]    end_y,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  line_clear
);

    glos_cmd_t cmd;
    glos_sts_t sts;

    glos_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    glos_dp #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cell_index (cell_index),
        .cell_free  (cell_free),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .cmd        (cmd),
        .sts        (sts),
        .line_clear (line_clear)
    );

endmodule
